/* hdl/bpk_pkg.sv */
// Shared types and constants for the MSB-first bit packer.
`timescale 1ns / 1ps
package bpk_pkg;

	localparam int CODE_W        = 64;
	localparam int LEN_W         = 7;
	localparam int MAX_CODE_BITS = 64;
	localparam int BYTE_W        = 8;
	localparam int FILL_W        = 4;
	localparam int QDEPTH        = 2;
	localparam int QPTR_W        = 1;
	localparam int QCNT_W        = 2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// Byte-full fill level, also the flag for "exactly filled and already sent"
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BYTE_W);

	// Command held in the queue between front and back
	typedef struct packed {
		logic              kind;
		logic [CODE_W-1:0] code;          // left aligned, unused low bits zero
		logic [LEN_W-1:0]  len;           // clamped, never zero for a write
		logic              append_count;
	} cmd_t;

	// Back-end status seen at the top level
	typedef struct packed {
		logic              busy;
		logic [FILL_W-1:0] bits_filled;
	} status_t;

endpackage

/* hdl/bpk_front.sv */
// Front end: accepts items, drops empty writes, aligns codes, queues commands.
`timescale 1ns / 1ps
module bpk_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        kind,
	input  logic [bpk_pkg::CODE_W-1:0]  code_bits,
	input  logic [bpk_pkg::LEN_W-1:0]   code_length,
	input  logic                        append_count,
	output logic                        hd_valid,
	output bpk_pkg::cmd_t               hd,
	input  logic                        deq
);

	bpk_pkg::cmd_t                    fifo_q [bpk_pkg::QDEPTH];
	logic [bpk_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [bpk_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [bpk_pkg::QCNT_W-1:0]       cnt_q;
	logic [bpk_pkg::LEN_W-1:0]        len_c;
	logic [bpk_pkg::LEN_W-1:0]        shamt;
	logic                             accept;
	logic                             enq;
	bpk_pkg::cmd_t                    cmd;

	assign full     = (cnt_q == bpk_pkg::QCNT_W'(bpk_pkg::QDEPTH));
	assign hd_valid = (cnt_q != '0);
	assign hd       = fifo_q[rd_ptr_q];
	assign accept   = push && !full;

	// Clamp the length and left-align the code so the back takes bits from the top
	always_comb begin
		if (code_length > bpk_pkg::LEN_W'(bpk_pkg::MAX_CODE_BITS)) begin
			len_c = bpk_pkg::LEN_W'(bpk_pkg::MAX_CODE_BITS);
		end else begin
			len_c = code_length;
		end
		shamt            = bpk_pkg::LEN_W'(bpk_pkg::CODE_W) - len_c;
		cmd.kind         = kind;
		cmd.code         = code_bits << shamt;
		cmd.len          = len_c;
		cmd.append_count = append_count;
	end

	// Drop zero-length writes: they change nothing
	assign enq = accept && !(kind == bpk_pkg::KIND_WRITE && code_length == '0);

	// Queue storage
	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!enq && deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/bpk_back.sv */
// Back end: packs queued commands into bytes and holds the result register.
`timescale 1ns / 1ps
module bpk_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        hd_valid,
	input  bpk_pkg::cmd_t               hd,
	output logic                        deq,
	output logic                        empty,
	input  logic                        pop,
	output logic [bpk_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last,
	output bpk_pkg::status_t            status
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WRITE = 3'b010,
		ST_COUNT = 3'b100
	} state_t;

	state_t                           state_q, state_d;
	logic [bpk_pkg::BYTE_W-1:0]       pend_q, pend_d;
	logic [bpk_pkg::FILL_W-1:0]       bf_q, bf_d;
	logic [bpk_pkg::CODE_W-1:0]       code_q, code_d;
	logic [bpk_pkg::LEN_W-1:0]        rem_q, rem_d;
	logic [bpk_pkg::FILL_W-1:0]       cnt_q, cnt_d;
	logic                             out_valid_q;
	logic [bpk_pkg::BYTE_W-1:0]       out_byte_q;
	logic                             last_q;

	logic [bpk_pkg::CODE_W-1:0]       src_code;
	logic [bpk_pkg::LEN_W-1:0]        src_rem;
	logic [bpk_pkg::FILL_W-1:0]       bfe, space, take, sum;
	logic [bpk_pkg::BYTE_W-1:0]       merged;
	logic [bpk_pkg::LEN_W-1:0]        rem_n;
	logic [bpk_pkg::CODE_W-1:0]       code_n;
	logic                             w_emit, w_last;
	logic                             out_free;
	logic                             ld;
	logic [bpk_pkg::BYTE_W-1:0]       ld_byte;
	logic                             ld_last;

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign last     = last_q;
	assign status   = '{busy: (state_q != ST_IDLE), bits_filled: bf_q};

	// One write step: fill the pending byte from the top of the aligned code
	always_comb begin
		if (state_q == ST_WRITE) begin
			src_code = code_q;
			src_rem  = rem_q;
		end else begin
			src_code = hd.code;
			src_rem  = hd.len;
		end
		bfe   = (bf_q == bpk_pkg::FILL_FULL) ? '0 : bf_q;
		space = bpk_pkg::FILL_FULL - bfe;
		if (bpk_pkg::LEN_W'(space) > src_rem) begin
			take = src_rem[bpk_pkg::FILL_W-1:0];
		end else begin
			take = space;
		end
		sum    = bfe + take;
		w_emit = (sum == bpk_pkg::FILL_FULL);
		merged = pend_q | (src_code[bpk_pkg::CODE_W-1 -: bpk_pkg::BYTE_W] >> bfe);
		rem_n  = src_rem - bpk_pkg::LEN_W'(take);
		code_n = src_code << take;
		// No further byte can follow once fewer than eight bits remain
		w_last = (rem_n < bpk_pkg::LEN_W'(bpk_pkg::BYTE_W));
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		bf_d    = bf_q;
		code_d  = code_q;
		rem_d   = rem_q;
		cnt_d   = cnt_q;
		deq     = 1'b0;
		ld      = 1'b0;
		ld_byte = merged;
		ld_last = w_last;
		case (state_q)
			ST_IDLE: begin
				if (hd_valid) begin
					if (hd.kind == bpk_pkg::KIND_WRITE) begin
						if (!w_emit || out_free) begin
							deq = 1'b1;
							ld  = w_emit;
							if (w_emit) begin
								pend_d = '0;
								bf_d   = bpk_pkg::FILL_FULL;
							end else begin
								pend_d = merged;
								bf_d   = sum;
							end
							if (rem_n != '0) begin
								code_d  = code_n;
								rem_d   = rem_n;
								state_d = ST_WRITE;
							end
						end
					end else if (bf_q == '0) begin
						deq = 1'b1;
					end else if (bf_q == bpk_pkg::FILL_FULL) begin
						// Byte already sent; only the count byte may follow
						if (!hd.append_count || out_free) begin
							deq     = 1'b1;
							ld      = hd.append_count;
							ld_byte = bpk_pkg::BYTE_W'(bpk_pkg::FILL_FULL);
							ld_last = 1'b1;
							pend_d  = '0;
							bf_d    = '0;
						end
					end else if (out_free) begin
						// Send the padded byte, then the count byte if asked
						deq     = 1'b1;
						ld      = 1'b1;
						ld_byte = pend_q;
						ld_last = !hd.append_count;
						cnt_d   = bf_q;
						pend_d  = '0;
						bf_d    = '0;
						if (hd.append_count) begin
							state_d = ST_COUNT;
						end
					end
				end
			end
			ST_WRITE: begin
				if (!w_emit || out_free) begin
					ld = w_emit;
					if (w_emit) begin
						pend_d = '0;
						bf_d   = bpk_pkg::FILL_FULL;
					end else begin
						pend_d = merged;
						bf_d   = sum;
					end
					code_d = code_n;
					rem_d  = rem_n;
					if (rem_n == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_COUNT: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_byte = bpk_pkg::BYTE_W'(cnt_q);
					ld_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= '0;
			bf_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			bf_q    <= bf_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Work registers and result payload
	always_ff @(posedge clk) begin
		code_q <= code_d;
		rem_q  <= rem_d;
		cnt_q  <= cnt_d;
		if (ld) begin
			out_byte_q <= ld_byte;
			last_q     <= ld_last;
		end
	end

endmodule

/* hdl/msb_first_bit_packer.sv */
// MSB-first bit packer: a 2-deep command queue feeds a one-byte-per-cycle packing sequencer.
// An accepted item is registered in the queue; the sequencer loads its bytes into the
//   result register. Steps: a write takes ceil((held bits + len) / 8) byte-fill steps, at
//   least 1, so 1 to 9; a flush takes one step, two if a count byte follows a padded byte.
// One command at a time is in work; a held result stalls any step that loads a byte.
// Reset (arst_n low) empties the queue and the result register and clears the pending byte.
`timescale 1ns / 1ps
module msb_first_bit_packer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        kind,
	input  logic [bpk_pkg::CODE_W-1:0]  code_bits,
	input  logic [bpk_pkg::LEN_W-1:0]   code_length,
	input  logic                        append_count,
	output logic                        empty,
	input  logic                        pop,
	output logic [bpk_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last
);

	logic              hd_valid;
	bpk_pkg::cmd_t     hd;
	logic              deq;
	bpk_pkg::status_t  status;

	bpk_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.append_count (append_count),
		.hd_valid     (hd_valid),
		.hd           (hd),
		.deq          (deq)
	);

	bpk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.hd_valid (hd_valid),
		.hd       (hd),
		.deq      (deq),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last     (last),
		.status   (status)
	);

	// Consume a command only when one is queued
	a_deq_valid: assert property (@(posedge clk) disable iff (!arst_n) deq |-> hd_valid)
		else $error("command consumed from an empty queue");

	// Fill level never passes a full byte
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.bits_filled <= bpk_pkg::FILL_FULL)
		else $error("pending fill level out of range");

	// A full queue always presents a command
	a_full_head: assert property (@(posedge clk) disable iff (!arst_n) full |-> hd_valid)
		else $error("queue full without a head command");

	// Sequencer busy means the queue head was taken, so no second take until idle
	a_busy_no_deq: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> !deq)
		else $error("command consumed while sequencer busy");

endmodule

/* tb/sv/tb_msb_first_bit_packer.sv */
// Self-checking testbench for the MSB-first bit packer: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_msb_first_bit_packer;

	localparam int DIRECTED_ROWS = 22;
	localparam int RANDOM_ITEMS  = 438;
	localparam int QUIET_TAIL    = 90;
	localparam int HOLD_AT       = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_PAUSE   = 250;
	localparam int SETTLE_CYCLES = 24;
	localparam int LIMIT_CYCLES  = 400000;

	// One output byte and its end-of-item flag
	typedef struct packed {
		logic [bpk_pkg::BYTE_W-1:0] b;
		logic                       last;
	} out_rec_t;

	// Directed row: n_exp < 0 means the predictor supplies the expectation
	typedef struct packed {
		logic                       kind;
		logic [bpk_pkg::CODE_W-1:0] code;
		logic [bpk_pkg::LEN_W-1:0]  len;
		logic                       acnt;
		int                         n_exp;
		logic [63:0]                exp_b;   // first expected byte in bits 63:56
	} dir_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         push;
	logic                         full;
	logic                         kind;
	logic [bpk_pkg::CODE_W-1:0]   code_bits;
	logic [bpk_pkg::LEN_W-1:0]    code_length;
	logic                         append_count;
	logic                         empty;
	logic                         pop;
	logic [bpk_pkg::BYTE_W-1:0]   out_byte;
	logic                         last;

	// Predictor state: byte under construction and its fill level
	logic [bpk_pkg::BYTE_W-1:0]   pk_byte;
	logic [bpk_pkg::FILL_W-1:0]   pk_fill;
	logic [bpk_pkg::BYTE_W-1:0]   packed_bytes[$];
	out_rec_t                     expected_bytes[$];

	int                  items_taken;
	int                  mismatches;
	int                  cyc_count;
	bit                  calm;
	bit                  tail;

	dir_row_t dir_tbl [0:DIRECTED_ROWS-1] = '{
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b1, 0, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b0, 8,
			64'hFFFF_FFFF_FFFF_FFFF},
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b1, 1, 64'h0800_0000_0000_0000},
		'{bpk_pkg::KIND_WRITE, 64'hDEAD_BEEF_0000_0001, 7'd0, 1'b1, 0, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'h1, 7'd1, 1'b0, 0, 64'h0},
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b1, 2, 64'h8001_0000_0000_0000},
		'{bpk_pkg::KIND_WRITE, 64'h0, 7'd64, 1'b1, 8, 64'h0},
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b0, 0, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, 8,
			64'hFFFF_FFFF_FFFF_FFFF},
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b0, 0, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'h16, 7'd5, 1'b1, -1, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'hA, 7'd4, 1'b0, -1, 64'h0},
		'{bpk_pkg::KIND_FLUSH, 64'hFFFF_0000_FFFF_0000, 7'd64, 1'b1, -1, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'h7F, 7'd7, 1'b0, -1, 64'h0},
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b0, -1, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'h8000_0000_0000_0001, 7'd64, 1'b0, -1, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'h0123_4567_89AB_CDEF, 7'd65, 1'b0, -1, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFF8, 7'd3, 1'b0, -1, 64'h0},
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b1, -1, 64'h0},
		'{bpk_pkg::KIND_WRITE, 64'h1FF, 7'd9, 1'b0, -1, 64'h0},
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b1, -1, 64'h0},
		'{bpk_pkg::KIND_FLUSH, 64'h0, 7'd0, 1'b1, 0, 64'h0}
	};

	msb_first_bit_packer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.append_count (append_count),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.last         (last)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Compute the bytes one item produces and advance the predictor state
	function automatic void pack_code(input logic k, input logic [bpk_pkg::CODE_W-1:0] code,
			input logic [bpk_pkg::LEN_W-1:0] len, input logic acnt);
		int nbits;
		int i;
		packed_bytes.delete();
		if (k == bpk_pkg::KIND_WRITE) begin
			nbits = (int'(len) > bpk_pkg::MAX_CODE_BITS) ? bpk_pkg::MAX_CODE_BITS : int'(len);
			for (i = nbits - 1; i >= 0; i--) begin
				// start a fresh byte once an exactly filled one went out
				if (pk_fill >= bpk_pkg::FILL_FULL) begin
					pk_fill = '0;
					pk_byte = '0;
				end
				pk_byte[7 - pk_fill] = code[i];
				pk_fill = pk_fill + 1'b1;
				if (pk_fill == bpk_pkg::FILL_FULL) begin
					packed_bytes.push_back(pk_byte);
					pk_byte = '0;
				end
			end
		end else begin
			if (pk_fill >= bpk_pkg::FILL_FULL) begin
				if (acnt)
					packed_bytes.push_back(bpk_pkg::BYTE_W'(8));
			end else if (pk_fill != 0) begin
				packed_bytes.push_back(pk_byte & (8'hFF << (8 - pk_fill)));
				if (acnt)
					packed_bytes.push_back(bpk_pkg::BYTE_W'(pk_fill));
			end
			pk_byte = '0;
			pk_fill = '0;
		end
	endfunction

	// Offer one item, hold it until accepted, then record what it should produce
	task automatic send_item(input logic k, input logic [bpk_pkg::CODE_W-1:0] code,
			input logic [bpk_pkg::LEN_W-1:0] len, input logic acnt, input int n_exp,
			input logic [63:0] exp_b, input int gap);
		out_rec_t r;
		int j;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind         <= k;
		code_bits    <= code;
		code_length  <= len;
		append_count <= acnt;
		push         <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pack_code(k, code, len, acnt);
		if (n_exp < 0) begin
			for (j = 0; j < packed_bytes.size(); j++) begin
				r.b    = packed_bytes[j];
				r.last = (j == packed_bytes.size() - 1);
				expected_bytes.push_back(r);
			end
		end else begin
			for (j = 0; j < n_exp; j++) begin
				r.b    = exp_b[63 - 8*j -: 8];
				r.last = (j == n_exp - 1);
				expected_bytes.push_back(r);
			end
		end
		items_taken++;
	endtask

	// Pick an occasional idle gap before the next item, none when quiet
	function automatic int pick_gap();
		if (calm || tail || $urandom_range(0, 5) != 0)
			return 0;
		return $urandom_range(1, 14);
	endfunction

	// Check each output transaction and drive pop with random stalls
	initial begin : receiver
		out_rec_t r;
		int  stall_left;
		bit  held;
		stall_left = 0;
		held       = 1'b0;
		pop        = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected byte %02h last %0b", $time, out_byte, last);
					mismatches++;
				end else begin
					r = expected_bytes.pop_front();
					if (out_byte !== r.b) begin
						$display("%0t: out_byte mismatch, expected %02h, got %02h",
							$time, r.b, out_byte);
						mismatches++;
					end
					if (last !== r.last) begin
						$display("%0t: last mismatch, expected %0b, got %0b",
							$time, r.last, last);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!held && items_taken >= HOLD_AT) begin
				// hold off long enough for the block to fill and stall its input
				held       = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				pop        <= 1'b0;
			end else if (!calm && !tail && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 13);
				pop        <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// End the run if it stalls
	initial begin : watchdog
		cyc_count = 0;
		while (cyc_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cyc_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Reset, directed table, random traffic, drain, verdict
	initial begin : stimulus
		logic                       k;
		logic [bpk_pkg::CODE_W-1:0] code;
		logic [bpk_pkg::LEN_W-1:0]  len;
		int                         sel;
		int                         n;
		arst_n       = 1'b0;
		push         = 1'b0;
		kind         = bpk_pkg::KIND_WRITE;
		code_bits    = '0;
		code_length  = '0;
		append_count = 1'b0;
		pk_byte      = '0;
		pk_fill      = '0;
		items_taken  = 0;
		mismatches   = 0;
		calm         = 1'b0;
		tail         = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_ROWS; n++)
			send_item(dir_tbl[n].kind, dir_tbl[n].code, dir_tbl[n].len, dir_tbl[n].acnt,
				dir_tbl[n].n_exp, dir_tbl[n].exp_b, pick_gap());

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// switch between idling and calm stretches
			if (n % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			tail = (n >= RANDOM_ITEMS - QUIET_TAIL);
			if (n == DRAIN_PAUSE) begin
				push <= 1'b0;
				@(posedge clk);
				while (expected_bytes.size() != 0)
					@(posedge clk);
			end
			k    = ($urandom_range(0, 99) < 18) ? bpk_pkg::KIND_FLUSH : bpk_pkg::KIND_WRITE;
			code = {$urandom, $urandom};
			sel  = $urandom_range(0, 99);
			if (sel < 3)
				len = '0;
			else if (sel < 7)
				len = bpk_pkg::LEN_W'($urandom_range(65, 127));
			else if (sel < 12)
				len = bpk_pkg::LEN_W'(bpk_pkg::MAX_CODE_BITS);
			else if (sel < 22)
				len = bpk_pkg::LEN_W'($urandom_range(17, 63));
			else
				len = bpk_pkg::LEN_W'($urandom_range(1, 16));
			send_item(k, code, len, 1'($urandom_range(0, 1)), -1, 64'h0, pick_gap());
		end
		push <= 1'b0;

		// drain outstanding bytes, then watch for strays
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
hdl/bpk_pkg.sv
hdl/bpk_front.sv
hdl/bpk_back.sv
hdl/msb_first_bit_packer.sv
tb/sv/tb_msb_first_bit_packer.sv
